// ===== design/sft_pkg.sv =====
package sft_pkg;

  localparam int NUM_SERVERS_DEF = 4;
  localparam int SEL_W           = 3;
  localparam int TIME_W          = 32;
  localparam int CNT_W           = 16;
  localparam int MASK_W          = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THRESHOLD = 2'd2;

  localparam logic [TIME_W-1:0] WINDOW_MS_RST      = 32'd10000;
  localparam logic [TIME_W-1:0] HOLD_MS_RST        = 32'd300000;
  localparam logic [CNT_W-1:0]  FAIL_THRESHOLD_RST = 16'd5;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  localparam logic CMD_TIMEOUT = 1'b0;
  localparam logic CMD_CHECK   = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [SEL_W-1:0]  server_sel;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] window_ms;
    logic [TIME_W-1:0] hold_ms;
    logic [CNT_W-1:0]  fail_threshold;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [MASK_W-1:0] failover_mask;
    logic [MASK_W-1:0] changed_mask;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WIN,
    ST_ACT,
    ST_DONE
  } state_t;

endpackage

// ===== design/sft_in_if.sv =====
interface sft_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [sft_pkg::SEL_W-1:0]      server_sel;
  logic [sft_pkg::TIME_W-1:0]     now_ms;

  modport source (output valid, cmd, server_sel, now_ms, input ready);
  modport sink   (input valid, cmd, server_sel, now_ms, output ready);
endinterface

// ===== design/sft_out_if.sv =====
interface sft_out_if;
  logic                        valid;
  logic                        ready;
  logic [sft_pkg::MASK_W-1:0]  failover_mask;
  logic [sft_pkg::MASK_W-1:0]  changed_mask;

  modport source (output valid, failover_mask, changed_mask, input ready);
  modport sink   (input valid, failover_mask, changed_mask, output ready);
endinterface

// ===== design/sft_cfg_if.sv =====
interface sft_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sft_pkg::CFG_IDX_W-1:0]  index;
  logic [sft_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/sft_elapsed_cmp.sv =====
module sft_elapsed_cmp (
  input  logic [sft_pkg::TIME_W-1:0] op_a,
  input  logic [sft_pkg::TIME_W-1:0] op_b,
  input  logic [sft_pkg::TIME_W-1:0] op_c,
  output logic                       ge
);

  logic [sft_pkg::TIME_W-1:0] diff;

  // modulo 2^32 difference, so a wrapping tick counter needs no special case
  assign diff = op_a - op_b;
  assign ge   = (diff >= op_c);

endmodule

// ===== design/sft_seq.sv =====
module sft_seq #(
  parameter int NUM_SERVERS = sft_pkg::NUM_SERVERS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  sft_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_ready,
  input  sft_pkg::cfg_t  cfg,
  output sft_pkg::res_t  res,
  input  logic           res_take
);

  localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SERVERS - 1);

  sft_pkg::state_t state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [sft_pkg::TIME_W-1:0] now_q;
  logic [NUM_SERVERS-1:0] prior_mask;
  logic [NUM_SERVERS-1:0] failed;
  logic [sft_pkg::CNT_W-1:0]  count  [NUM_SERVERS];
  logic [sft_pkg::TIME_W-1:0] wstart [NUM_SERVERS];
  logic [sft_pkg::TIME_W-1:0] fstart [NUM_SERVERS];

  logic [sft_pkg::TIME_W-1:0] op_a, op_b, op_c;
  logic ge;
  logic upd_evt, upd_win, upd_ret, upd_fail, take_item;
  logic [IDX_W-1:0] sel_idx;
  logic sel_ok;

  sft_elapsed_cmp u_cmp (
    .op_a (op_a),
    .op_b (op_b),
    .op_c (op_c),
    .ge   (ge)
  );

  assign sel_idx = item.server_sel[IDX_W-1:0];
  assign sel_ok  = (4'(item.server_sel) < 4'(NUM_SERVERS));

  always_comb begin
    state_next = state;
    idx_next   = idx;
    op_a       = now_q;
    op_b       = wstart[idx];
    op_c       = cfg.window_ms;
    upd_evt    = 1'b0;
    upd_win    = 1'b0;
    upd_ret    = 1'b0;
    upd_fail   = 1'b0;
    take_item  = 1'b0;
    case (state)
      sft_pkg::ST_IDLE: begin
        if (item_valid) begin
          take_item = 1'b1;
          idx_next  = '0;
          if (item.cmd == sft_pkg::CMD_CHECK) begin
            state_next = sft_pkg::ST_WIN;
          end else begin
            upd_evt    = sel_ok && (count[sel_idx] != sft_pkg::CNT_MAX);
            state_next = sft_pkg::ST_DONE;
          end
        end
      end
      sft_pkg::ST_WIN: begin
        if (ge) begin
          upd_win = 1'b1;
          if (idx == IDX_LAST) begin
            state_next = sft_pkg::ST_DONE;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = sft_pkg::ST_WIN;
          end
        end else begin
          state_next = sft_pkg::ST_ACT;
        end
      end
      sft_pkg::ST_ACT: begin
        if (failed[idx]) begin
          op_b    = fstart[idx];
          op_c    = cfg.hold_ms;
          upd_ret = ge;
        end else begin
          // reuse the unit as a plain count >= threshold compare
          op_a     = {{(sft_pkg::TIME_W - sft_pkg::CNT_W){1'b0}}, count[idx]};
          op_b     = '0;
          op_c     = {{(sft_pkg::TIME_W - sft_pkg::CNT_W){1'b0}}, cfg.fail_threshold};
          upd_fail = ge;
        end
        if (idx == IDX_LAST) begin
          state_next = sft_pkg::ST_DONE;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = sft_pkg::ST_WIN;
        end
      end
      sft_pkg::ST_DONE: begin
        if (res_take) begin
          state_next = sft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sft_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sft_pkg::ST_IDLE;
      idx    <= '0;
      failed <= '0;
      for (int s = 0; s < NUM_SERVERS; s++) begin
        count[s]  <= '0;
        wstart[s] <= '0;
        fstart[s] <= '0;
      end
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (upd_evt) begin
        count[sel_idx] <= count[sel_idx] + sft_pkg::CNT_W'(1);
      end
      if (upd_win) begin
        wstart[idx] <= now_q;
        count[idx]  <= '0;
      end
      if (upd_ret) begin
        failed[idx] <= 1'b0;
        count[idx]  <= '0;
        fstart[idx] <= '0;
      end
      if (upd_fail) begin
        failed[idx] <= 1'b1;
        count[idx]  <= '0;
        fstart[idx] <= now_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      now_q      <= item.now_ms;
      prior_mask <= failed;
    end
  end

  assign item_ready        = (state == sft_pkg::ST_IDLE);
  assign res.valid         = (state == sft_pkg::ST_DONE);
  assign res.failover_mask = sft_pkg::MASK_W'(failed);
  assign res.changed_mask  = sft_pkg::MASK_W'(failed ^ prior_mask);

endmodule

// ===== design/server_failover_timeout_tracker.sv =====
// Per-server timeout tracking with failover to an alternate. A timeout event
// (cmd 0) bumps one server's saturating count and yields one result word; a
// check pass (cmd 1) walks the servers in order through one shared
// subtract-and-compare unit, one compare per cycle: a server whose window has
// elapsed takes only the window step (ST_WIN), any other the action step
// (ST_ACT) as well. Input is taken only between items; the output register
// lets the next item be accepted while the last result word still waits.
// Configuration writes are always accepted and should be issued only while
// the block is idle.
module server_failover_timeout_tracker #(
  parameter int NUM_SERVERS = sft_pkg::NUM_SERVERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sft_in_if.sink      in_ch,
  sft_out_if.source   out_ch,
  sft_cfg_if.sink     cfg_ch
);

  sft_pkg::cfg_t  cfg;
  sft_pkg::item_t item;
  sft_pkg::res_t  res;
  logic res_take;
  logic out_valid;
  logic [sft_pkg::MASK_W-1:0] out_fmask, out_cmask;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ms      <= sft_pkg::WINDOW_MS_RST;
      cfg.hold_ms        <= sft_pkg::HOLD_MS_RST;
      cfg.fail_threshold <= sft_pkg::FAIL_THRESHOLD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        sft_pkg::CFG_WINDOW_MS:      cfg.window_ms      <= cfg_ch.data;
        sft_pkg::CFG_HOLD_MS:        cfg.hold_ms        <= cfg_ch.data;
        sft_pkg::CFG_FAIL_THRESHOLD: cfg.fail_threshold <= cfg_ch.data[sft_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item.cmd        = in_ch.cmd;
  assign item.server_sel = in_ch.server_sel;
  assign item.now_ms     = in_ch.now_ms;

  sft_seq #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (in_ch.valid),
    .item_ready (in_ch.ready),
    .cfg        (cfg),
    .res        (res),
    .res_take   (res_take)
  );

  // output slot is free when empty or being drained this cycle
  assign res_take = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res.valid) begin
      out_fmask <= res.failover_mask;
      out_cmask <= res.changed_mask;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.failover_mask = out_fmask;
  assign out_ch.changed_mask  = out_cmask;

endmodule

// ===== design/sft_checker.sv =====
module sft_checker #(
  parameter int NUM_SERVERS = sft_pkg::NUM_SERVERS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sft_pkg::MASK_W-1:0] failover_mask,
  input logic [sft_pkg::MASK_W-1:0] changed_mask
);

  localparam logic [sft_pkg::MASK_W-1:0] SRV_BITS =
    sft_pkg::MASK_W'((1 << NUM_SERVERS) - 1);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(failover_mask) && $stable(changed_mask))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before item finished");

  a_mask_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((failover_mask & ~SRV_BITS) == '0) && ((changed_mask & ~SRV_BITS) == '0))
    else $error("mask bit set beyond last server");

endmodule

bind server_failover_timeout_tracker sft_checker #(
  .NUM_SERVERS (NUM_SERVERS)
) u_sft_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .failover_mask (out_ch.failover_mask),
  .changed_mask  (out_ch.changed_mask)
);

// ===== sim/server_failover_timeout_tracker_tb.sv =====
`timescale 1ns / 100ps

module server_failover_timeout_tracker_tb;

  localparam int NSRV        = sft_pkg::NUM_SERVERS_DEF;
  localparam int STALL_MAX   = 19;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 24;
  localparam int PHASES      = 9;
  localparam int PHASE_WORDS = 140;

  typedef struct packed {
    logic [sft_pkg::MASK_W-1:0] failover;
    logic [sft_pkg::MASK_W-1:0] changed;
  } mask_pair_t;

  logic clk = 1'b0;
  logic rst;

  sft_in_if  in_ch ();
  sft_out_if out_ch ();
  sft_cfg_if cfg_ch ();

  server_failover_timeout_tracker uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // shadow of the tracker
  sft_pkg::cfg_t              live_cfg;
  logic [sft_pkg::CNT_W-1:0]  tmo_count [NSRV];
  logic                       on_alt    [NSRV];
  logic [sft_pkg::TIME_W-1:0] win_start [NSRV];
  logic [sft_pkg::TIME_W-1:0] alt_start [NSRV];
  mask_pair_t                 pending_masks [$];

  logic [sft_pkg::TIME_W-1:0] tick;
  bit                pace_on;
  int                mismatch_count;
  int                sink_hold = 0;
  int                sink_gap;
  int                quiet_cycles = 0;

  function automatic logic [sft_pkg::MASK_W-1:0] alt_mask();
    logic [sft_pkg::MASK_W-1:0] m;
    int s;
    m = '0;
    for (s = 0; s < NSRV; s++)
      if (on_alt[s])
        m[s] = 1'b1;
    return m;
  endfunction

  task automatic clear_tracker();
    int s;
    live_cfg.window_ms      = sft_pkg::WINDOW_MS_RST;
    live_cfg.hold_ms        = sft_pkg::HOLD_MS_RST;
    live_cfg.fail_threshold = sft_pkg::FAIL_THRESHOLD_RST;
    for (s = 0; s < NSRV; s++) begin
      tmo_count[s] = '0;
      on_alt[s]    = 1'b0;
      win_start[s] = '0;
      alt_start[s] = '0;
    end
  endtask

  task automatic track_item(input logic c, input logic [sft_pkg::SEL_W-1:0] sel,
                            input logic [sft_pkg::TIME_W-1:0] now);
    logic [sft_pkg::MASK_W-1:0] prior;
    logic [sft_pkg::TIME_W-1:0] elapsed;
    mask_pair_t m;
    int s;
    prior = alt_mask();
    if (c == sft_pkg::CMD_TIMEOUT) begin
      if (sel < NSRV) begin
        if (tmo_count[sel] != sft_pkg::CNT_MAX)
          tmo_count[sel] = tmo_count[sel] + 1'b1;
      end
    end else begin
      for (s = 0; s < NSRV; s++) begin
        elapsed = now - win_start[s];
        if (elapsed >= live_cfg.window_ms) begin
          // window over: restart it and skip the rest for this server
          win_start[s] = now;
          tmo_count[s] = '0;
        end else if (on_alt[s]) begin
          elapsed = now - alt_start[s];
          if (elapsed >= live_cfg.hold_ms) begin
            on_alt[s]    = 1'b0;
            tmo_count[s] = '0;
            alt_start[s] = '0;
          end
        end else if (tmo_count[s] >= live_cfg.fail_threshold) begin
          on_alt[s]    = 1'b1;
          tmo_count[s] = '0;
          alt_start[s] = now;
        end
      end
    end
    m.failover = alt_mask();
    m.changed  = m.failover ^ prior;
    pending_masks.push_back(m);
  endtask

  task automatic report_mismatch(input string what, input logic [sft_pkg::MASK_W-1:0] want,
                                 input logic [sft_pkg::MASK_W-1:0] got);
    $display("%0t: %s mismatch, expected %02h got %02h", $time, what, want, got);
    mismatch_count++;
  endtask

  // hold valid across back-to-back words; drop it only ahead of a gap
  task automatic send_word(input logic c, input logic [sft_pkg::SEL_W-1:0] sel,
                           input logic [sft_pkg::TIME_W-1:0] now);
    int gap;
    gap = pace_on ? $urandom_range(0, STALL_MAX) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.server_sel <= sel;
    in_ch.now_ms     <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_item(c, sel, now);
  endtask

  task automatic timeout_word(input logic [sft_pkg::SEL_W-1:0] sel);
    send_word(sft_pkg::CMD_TIMEOUT, sel, $urandom);
  endtask

  task automatic check_at(input logic [sft_pkg::TIME_W-1:0] now);
    tick = now;
    send_word(sft_pkg::CMD_CHECK, sft_pkg::SEL_W'($urandom), now);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_word(input logic [sft_pkg::CFG_IDX_W-1:0] idx,
                          input logic [sft_pkg::CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      sft_pkg::CFG_WINDOW_MS:      live_cfg.window_ms = d;
      sft_pkg::CFG_HOLD_MS:        live_cfg.hold_ms = d;
      sft_pkg::CFG_FAIL_THRESHOLD: live_cfg.fail_threshold = d[sft_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [sft_pkg::TIME_W-1:0] win,
                            input logic [sft_pkg::TIME_W-1:0] hold,
                            input logic [sft_pkg::CNT_W-1:0] thr);
    wait_drained();
    cfg_word(sft_pkg::CFG_WINDOW_MS, win);
    cfg_word(sft_pkg::CFG_HOLD_MS, hold);
    // upper data bits are don't-care for the threshold
    cfg_word(sft_pkg::CFG_FAIL_THRESHOLD, {16'($urandom), thr});
    cfg_ch.valid <= 1'b0;
  endtask

  // result sink with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      sink_gap = pace_on ? $urandom_range(0, STALL_MAX) : 0;
      if (sink_gap == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        sink_hold    <= sink_gap - 1;
      end
    end else if (!out_ch.ready) begin
      if (sink_hold == 0)
        out_ch.ready <= 1'b1;
      else
        sink_hold <= sink_hold - 1;
    end
  end

  always @(posedge clk) begin : mask_check
    mask_pair_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_masks.size() == 0) begin
        report_mismatch("unexpected word, failover_mask", '0, out_ch.failover_mask);
      end else begin
        want = pending_masks[0];
        pending_masks.delete(0);
        if (out_ch.failover_mask !== want.failover)
          report_mismatch("failover_mask", want.failover, out_ch.failover_mask);
        if (out_ch.changed_mask !== want.changed)
          report_mismatch("changed_mask", want.changed, out_ch.changed_mask);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // default registers: counting, out-of-range servers, tick wrap
  task automatic test_reset_defaults();
    pace_on = 1'b1;
    timeout_word(3'd4);
    timeout_word(3'd7);
    repeat (5) timeout_word(3'd0);
    send_word(sft_pkg::CMD_TIMEOUT, 3'd1, '1);
    send_word(sft_pkg::CMD_TIMEOUT, 3'd1, '0);
    repeat (2) timeout_word(3'd1);
    timeout_word(3'd3);
    check_at(32'd100);
    timeout_word(3'd1);
    check_at(32'd200);
    check_at(32'hFFFF_FFFF);
    check_at(32'd5);
    repeat (3) timeout_word(3'd2);
    check_at(32'd9999);
    check_at(32'd10000);
  endtask

  // zero window, zero threshold, zero hold, and the top values
  task automatic test_register_corners();
    set_config('0, 32'($urandom), '0);
    repeat (2) timeout_word(3'd0);
    check_at(tick + 32'd7);
    check_at(tick + 32'd1);

    set_config('1, '0, '0);
    check_at(tick + 32'd3);
    check_at(tick + 32'd3);
    check_at(tick + 32'd3);

    set_config('1, '1, 16'd1);
    timeout_word(3'd2);
    check_at(tick + 32'd1);
    check_at(tick + 32'd1);

    set_config(32'd50, 32'd20, 16'd2);
    check_at(tick + 32'd60);
    repeat (2) timeout_word(3'd1);
    repeat (3) check_at(tick + 32'd12);
  endtask

  // pile timeouts on one server under the largest threshold
  task automatic test_high_threshold();
    logic [sft_pkg::SEL_W-1:0] srv;
    srv = sft_pkg::SEL_W'($urandom_range(0, NSRV - 1));
    set_config('1, '0, sft_pkg::CNT_MAX);
    check_at(tick + 32'd1);
    pace_on = 1'b0;
    repeat (40) timeout_word(srv);
    timeout_word(3'd5);
    timeout_word(3'd6);
    check_at(tick + 32'd1);
    check_at(tick + 32'd1);
  endtask

  task automatic test_random_traffic();
    logic [sft_pkg::TIME_W-1:0] win, hold;
    logic [sft_pkg::CNT_W-1:0]  thr;
    int p, n, r;
    for (p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       win = '0;
        1:       win = '1;
        2:       win = $urandom;
        default: win = $urandom_range(40, 3000);
      endcase
      case ($urandom_range(0, 9))
        0:       hold = '0;
        1:       hold = '1;
        2:       hold = $urandom;
        default: hold = $urandom_range(0, 4000);
      endcase
      case ($urandom_range(0, 9))
        0:       thr = '0;
        1:       thr = sft_pkg::CNT_MAX;
        default: thr = $urandom_range(1, 8);
      endcase
      set_config(win, hold, thr);
      pace_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0)
        tick = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      for (n = 0; n < PHASE_WORDS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 50)
          timeout_word(sft_pkg::SEL_W'($urandom_range(0, NSRV - 1)));
        else if (r < 55)
          timeout_word(sft_pkg::SEL_W'($urandom_range(NSRV, 7)));
        else if (r < 97)
          check_at(tick + $urandom_range(0, 300));
        else
          check_at(tick + $urandom);
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = sft_pkg::CMD_TIMEOUT;
    in_ch.server_sel  = '0;
    in_ch.now_ms      = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = sft_pkg::CFG_WINDOW_MS;
    cfg_ch.data       = '0;
    tick              = '0;
    pace_on           = 1'b0;
    mismatch_count    = 0;
    clear_tracker();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_register_corners();
    test_high_threshold();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_masks.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/sft_pkg.sv
design/sft_in_if.sv
design/sft_out_if.sv
design/sft_cfg_if.sv
design/sft_elapsed_cmp.sv
design/sft_seq.sv
design/server_failover_timeout_tracker.sv
design/sft_checker.sv
sim/server_failover_timeout_tracker_tb.sv
